/* rtl/pcrr_pkg.sv */
`default_nettype none
package pcrr_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CAP        = 3'd0;
    localparam logic [2:0] REG_TEMP_MAX   = 3'd1;
    localparam logic [2:0] REG_MARGIN     = 3'd2;
    localparam logic [2:0] REG_RATIO_MAX  = 3'd3;
    localparam logic [2:0] REG_WINDOW     = 3'd4;
    localparam logic [2:0] REG_STEP_UP    = 3'd5;
    localparam logic [2:0] REG_STEP_DOWN  = 3'd6;
    localparam logic [2:0] REG_PAUSE_MAX  = 3'd7;

    localparam int APB_AW = 5;

    localparam logic [19:0] CAP_RST        = 20'd250000;
    localparam logic [7:0]  TEMP_MAX_RST   = 8'd83;
    localparam logic [19:0] MARGIN_RST     = 20'd10000;
    localparam logic [23:0] RATIO_MAX_RST  = 24'd65536;
    localparam logic [19:0] WINDOW_RST     = 20'd10000;
    localparam logic [23:0] STEP_UP_RST    = 24'd3277;
    localparam logic [23:0] STEP_DOWN_RST  = 24'd1638;
    localparam logic [15:0] PAUSE_MAX_RST  = 16'd2000;

    localparam int MAX_INTERVAL_MS_DEF = 300000;

    localparam logic [19:0] CAP_MIN     = 20'd15000;
    localparam logic [19:0] WINDOW_MIN  = 20'd500;
    localparam logic [20:0] SEEN_MAX    = 21'h1FFFFF;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [3:0]  TAYLOR_LAST = 4'd12;
    localparam logic [3:0]  SQUARE_LAST = 4'd4;

    // Shared unit widths.
    localparam int DIV_NW = 36;
    localparam int DIV_DW = 20;
    localparam int MUL_W  = 32;

    typedef struct packed {
        logic [19:0] cap_mw;
        logic [7:0]  temp_max_c;
        logic [19:0] margin_mw;
        logic [23:0] rest_max_ratio;
        logic [19:0] window_ms;
        logic [23:0] step_up;
        logic [23:0] step_down;
        logic [15:0] pause_ceil_ms;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XDIV,
        ST_TMUL,
        ST_TDIV,
        ST_CLAMP,
        ST_SQ,
        ST_UPD,
        ST_REG,
        ST_PMUL,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

/* rtl/power_cap_rest_regulator.sv */
`default_nettype none
// Power cap rest regulator.
//
// Samples arrive on the s_ stream: tdata carries interval_ms, power_mw and
// temp_c, tuser carries the mode (boundary or pause slice) and the reading's
// valid flag. Each accepted request yields exactly one result on the m_
// stream: pause_ms, rest_ratio_out and average_mw in tdata, armed in tuser.
// Configuration registers sit on an APB-style port, four bytes apart. They
// are to be written only while the block is idle; it does not enforce this.
//
// One request is worked at a time by a small sequencer that reuses one
// restoring divider and one 32 x 16 multiplier. Each Taylor term takes two
// multiplies, the second by the reciprocal of the term index. s_tready is
// high only while the sequencer is idle, which it enters as the previous
// result is registered. A stalled receiver holds that result while the next
// request is accepted and computed; its own result then waits. Reset
// restores the register defaults, clears the average, time and ratio, and
// arms the seeding of the average by the first boundary sample.
module power_cap_rest_regulator
    import pcrr_pkg::*;
#(
    parameter int MAX_INTERVAL_MS = MAX_INTERVAL_MS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // interval_ms [19:0], power_mw [39:20], temp_c [47:40]
    input  wire logic [47:0]       s_tdata,
    // mode [0], sample_valid [1]
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // pause_ms [15:0], rest_ratio_out [39:16], average_mw [59:40], zero [63:60]
    output logic [63:0]            m_tdata,
    // armed [0]
    output logic [0:0]             m_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [20:0] MAX_IV = 21'(MAX_INTERVAL_MS);

    cfg_t cfg;

    pcrr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared units and their request registers.
    logic                div_go_reg, div_go_next;
    logic [DIV_NW-1:0]   div_n_reg, div_n_next;
    logic [DIV_DW-1:0]   div_d_reg, div_d_next;
    logic                div_done;
    logic [DIV_NW-1:0]   div_q;
    logic                mul_go_reg, mul_go_next;
    logic [MUL_W-1:0]    mul_a_reg, mul_a_next;
    logic [MUL_W-1:0]    mul_b_reg, mul_b_next;
    logic                mul_done;
    logic [2*MUL_W-1:0]  mul_p;

    pcrr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (div_go_reg),
        .dividend (div_n_reg),
        .divisor  (div_d_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    pcrr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (mul_go_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    // Sequencer state and the sample being worked.
    state_t              state_reg, state_next;
    logic                mode_reg, mode_next;
    logic [19:0]         dur_reg, dur_next;
    logic [19:0]         power_reg, power_next;
    logic [7:0]          temp_reg, temp_next;
    logic [28:0]         y_reg, y_next;
    logic signed [32:0]  sum_reg, sum_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [15:0]         pause_reg, pause_next;

    // Regulator state.
    logic [31:0]         avg_reg, avg_next;
    logic [20:0]         seen_reg, seen_next;
    logic [23:0]         ratio_reg, ratio_next;
    logic                first_reg, first_next;

    // Output register.
    logic                mv_reg, mv_next;
    logic [63:0]         md_reg, md_next;
    logic                mu_reg, mu_next;

    // Helper terms.
    logic [19:0]         weff;
    logic [19:0]         cap_eff;
    logic [31:0]         target;
    logic                tgt_ge;
    logic [31:0]         diff;
    logic                armed;
    logic [19:0]         in_iv;
    logic [19:0]         in_pw;
    logic [19:0]         in_dur;
    logic [29:0]         recip_m;
    logic [2:0]          recip_l;
    logic [30:0]         t_new;
    logic [30:0]         rn;
    logic [30:0]         r_clamp;
    logic [31:0]         delta;
    logic [21:0]         seen_sum;
    logic                hot;
    logic                over;
    logic                under;
    logic [24:0]         ratio_up;
    logic [23:0]         ratio_reg_new;
    logic [31:0]         pause_lim;

    assign weff    = (cfg.window_ms < WINDOW_MIN) ? WINDOW_MIN : cfg.window_ms;
    assign cap_eff = (cfg.cap_mw < CAP_MIN) ? CAP_MIN : cfg.cap_mw;
    assign target  = {power_reg, 12'd0};
    assign tgt_ge  = target >= avg_reg;
    assign diff    = tgt_ge ? (target - avg_reg) : (avg_reg - target);
    assign armed   = seen_reg >= {1'b0, weff};
    assign in_iv   = s_tdata[19:0];
    assign in_pw   = s_tdata[39:20];
    assign in_dur  = ({1'b0, in_iv} < MAX_IV) ? in_iv : 20'd0;
    assign rn      = mul_p[60:30];
    assign delta   = mul_p[61:30];
    assign seen_sum = {1'b0, seen_reg} + {2'b0, dur_reg};

    // Division of a term numerator (below 2^29) by the term index k is done
    // as a multiply by m = floor(2^(29+l) / k) + 1 and a shift by 29 + l,
    // with l = ceil(log2(k)). This is exact for every numerator below 2^29.
    always_comb begin
        case (cnt_reg)
            4'd1:    begin recip_m = 30'd536870913; recip_l = 3'd0; end
            4'd2:    begin recip_m = 30'd536870913; recip_l = 3'd1; end
            4'd3:    begin recip_m = 30'd715827883; recip_l = 3'd2; end
            4'd4:    begin recip_m = 30'd536870913; recip_l = 3'd2; end
            4'd5:    begin recip_m = 30'd858993460; recip_l = 3'd3; end
            4'd6:    begin recip_m = 30'd715827883; recip_l = 3'd3; end
            4'd7:    begin recip_m = 30'd613566757; recip_l = 3'd3; end
            4'd8:    begin recip_m = 30'd536870913; recip_l = 3'd3; end
            4'd9:    begin recip_m = 30'd954437177; recip_l = 3'd4; end
            4'd10:   begin recip_m = 30'd858993460; recip_l = 3'd4; end
            4'd11:   begin recip_m = 30'd780903145; recip_l = 3'd4; end
            4'd12:   begin recip_m = 30'd715827883; recip_l = 3'd4; end
            default: begin recip_m = 30'd536870913; recip_l = 3'd0; end
        endcase
    end

    always_comb begin
        case (recip_l)
            3'd0:    t_new = mul_p[59:29];
            3'd1:    t_new = mul_p[60:30];
            3'd2:    t_new = mul_p[61:31];
            3'd3:    t_new = mul_p[62:32];
            default: t_new = mul_p[63:33];
        endcase
    end

    always_comb begin
        if (sum_reg < 0) begin
            r_clamp = '0;
        end else if (sum_reg > $signed({2'b0, Q30_ONE})) begin
            r_clamp = Q30_ONE;
        end else begin
            r_clamp = sum_reg[30:0];
        end
    end

    // Ratio regulation. The low threshold exists only when the margin is
    // below the cap.
    assign hot   = (temp_reg != 8'd0) && (temp_reg > cfg.temp_max_c);
    assign over  = avg_reg > {cap_eff, 12'd0};
    assign under = (cfg.margin_mw < cap_eff)
                 && (avg_reg < {20'(cap_eff - cfg.margin_mw), 12'd0});
    assign ratio_up = {1'b0, ratio_reg} + {1'b0, cfg.step_up};

    always_comb begin
        if (over || hot) begin
            ratio_reg_new = (ratio_up > {1'b0, cfg.rest_max_ratio})
                          ? cfg.rest_max_ratio : ratio_up[23:0];
        end else if (under) begin
            ratio_reg_new = (ratio_reg > cfg.step_down) ? (ratio_reg - cfg.step_down) : 24'd0;
        end else begin
            ratio_reg_new = ratio_reg;
        end
    end

    assign pause_lim = {cfg.pause_ceil_ms, 16'd0};

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        dur_next    = dur_reg;
        power_next  = power_reg;
        temp_next   = temp_reg;
        y_next      = y_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        pause_next  = pause_reg;
        avg_next    = avg_reg;
        seen_next   = seen_reg;
        ratio_next  = ratio_reg;
        first_next  = first_reg;
        div_go_next = 1'b0;
        div_n_next  = div_n_reg;
        div_d_next  = div_d_reg;
        mul_go_next = 1'b0;
        mul_a_next  = mul_a_reg;
        mul_b_next  = mul_b_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        mu_next     = mu_reg;
        s_tready    = 1'b0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mode_next  = s_tuser[0];
                    power_next = in_pw;
                    temp_next  = s_tdata[47:40];
                    pause_next = 16'd0;
                    dur_next   = s_tuser[0] ? in_iv : in_dur;
                    div_n_next = {(s_tuser[0] ? in_iv : in_dur), 16'd0};
                    div_d_next = weff;
                    if (s_tuser[0]) begin
                        // Pause slices only move the average.
                        if (s_tuser[1] && in_iv != 20'd0) begin
                            div_go_next = 1'b1;
                            state_next  = ST_XDIV;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else if (first_reg) begin
                        // The first boundary sample seeds the average.
                        first_next = 1'b0;
                        if (s_tuser[1]) begin
                            avg_next = {in_pw, 12'd0};
                        end
                        state_next = ST_OUT;
                    end else if (s_tuser[1]) begin
                        if (in_dur != 20'd0) begin
                            div_go_next = 1'b1;
                            state_next  = ST_XDIV;
                        end else begin
                            state_next = ST_REG;
                        end
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_XDIV: begin
                if (div_done) begin
                    mul_go_next = 1'b1;
                    if (div_q[DIV_NW-1:20] != '0) begin
                        // Interval of sixteen windows or more: alpha is one.
                        mul_a_next = diff;
                        mul_b_next = {1'b0, Q30_ONE};
                        state_next = ST_UPD;
                    end else begin
                        y_next     = {div_q[19:0], 9'd0};
                        sum_next   = $signed({2'b0, Q30_ONE});
                        cnt_next   = 4'd1;
                        mul_a_next = {1'b0, Q30_ONE};
                        mul_b_next = {3'b0, div_q[19:0], 9'd0};
                        state_next = ST_TMUL;
                    end
                end
            end
            ST_TMUL: begin
                // Previous term times y is ready; scale by 1/k next.
                if (mul_done) begin
                    mul_go_next = 1'b1;
                    mul_a_next  = {3'd0, mul_p[58:30]};
                    mul_b_next  = {2'd0, recip_m};
                    state_next  = ST_TDIV;
                end
            end
            ST_TDIV: begin
                if (mul_done) begin
                    sum_next  = cnt_reg[0] ? (sum_reg - $signed({2'b0, t_new}))
                                           : (sum_reg + $signed({2'b0, t_new}));
                    if (cnt_reg == TAYLOR_LAST) begin
                        state_next = ST_CLAMP;
                    end else begin
                        cnt_next    = cnt_reg + 4'd1;
                        mul_go_next = 1'b1;
                        mul_a_next  = {1'b0, t_new};
                        mul_b_next  = {3'b0, y_reg};
                        state_next  = ST_TMUL;
                    end
                end
            end
            ST_CLAMP: begin
                cnt_next    = 4'd0;
                mul_go_next = 1'b1;
                mul_a_next  = {1'b0, r_clamp};
                mul_b_next  = {1'b0, r_clamp};
                state_next  = ST_SQ;
            end
            ST_SQ: begin
                if (mul_done) begin
                    mul_go_next = 1'b1;
                    if (cnt_reg == SQUARE_LAST) begin
                        mul_a_next = diff;
                        mul_b_next = {1'b0, 31'(Q30_ONE - rn)};
                        state_next = ST_UPD;
                    end else begin
                        cnt_next   = cnt_reg + 4'd1;
                        mul_a_next = {1'b0, rn};
                        mul_b_next = {1'b0, rn};
                    end
                end
            end
            ST_UPD: begin
                if (mul_done) begin
                    avg_next = tgt_ge ? (avg_reg + delta) : (avg_reg - delta);
                    if (mode_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        seen_next  = (seen_sum > {1'b0, SEEN_MAX}) ? SEEN_MAX
                                                                   : seen_sum[20:0];
                        state_next = ST_REG;
                    end
                end
            end
            ST_REG: begin
                state_next = ST_OUT;
                if (armed) begin
                    ratio_next = ratio_reg_new;
                    if (ratio_reg_new != 24'd0) begin
                        mul_go_next = 1'b1;
                        mul_a_next  = {8'd0, ratio_reg_new};
                        mul_b_next  = {12'd0, dur_reg};
                        state_next  = ST_PMUL;
                    end
                end
            end
            ST_PMUL: begin
                if (mul_done) begin
                    pause_next = (mul_p[43:0] > {12'd0, pause_lim}) ? cfg.pause_ceil_ms
                                                                    : mul_p[31:16];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {4'd0, avg_reg[31:12], ratio_reg, pause_reg};
                    mu_next    = armed;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            avg_reg    <= '0;
            seen_reg   <= '0;
            ratio_reg  <= '0;
            first_reg  <= 1'b1;
            mv_reg     <= 1'b0;
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            avg_reg    <= avg_next;
            seen_reg   <= seen_next;
            ratio_reg  <= ratio_next;
            first_reg  <= first_next;
            mv_reg     <= mv_next;
            div_go_reg <= div_go_next;
            mul_go_reg <= mul_go_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        dur_reg   <= dur_next;
        power_reg <= power_next;
        temp_reg  <= temp_next;
        y_reg     <= y_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        pause_reg <= pause_next;
        div_n_reg <= div_n_next;
        div_d_reg <= div_d_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

endmodule
`default_nettype wire

/* rtl/pcrr_cfg.sv */
`default_nettype none
module pcrr_cfg
    import pcrr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t        cfg_reg;
    logic [2:0]  idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cap_mw         <= CAP_RST;
            cfg_reg.temp_max_c     <= TEMP_MAX_RST;
            cfg_reg.margin_mw      <= MARGIN_RST;
            cfg_reg.rest_max_ratio <= RATIO_MAX_RST;
            cfg_reg.window_ms      <= WINDOW_RST;
            cfg_reg.step_up        <= STEP_UP_RST;
            cfg_reg.step_down      <= STEP_DOWN_RST;
            cfg_reg.pause_ceil_ms  <= PAUSE_MAX_RST;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_CAP:       cfg_reg.cap_mw         <= pwdata[19:0];
                REG_TEMP_MAX:  cfg_reg.temp_max_c     <= pwdata[7:0];
                REG_MARGIN:    cfg_reg.margin_mw      <= pwdata[19:0];
                REG_RATIO_MAX: cfg_reg.rest_max_ratio <= pwdata[23:0];
                REG_WINDOW:    cfg_reg.window_ms      <= pwdata[19:0];
                REG_STEP_UP:   cfg_reg.step_up        <= pwdata[23:0];
                REG_STEP_DOWN: cfg_reg.step_down      <= pwdata[23:0];
                REG_PAUSE_MAX: cfg_reg.pause_ceil_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CAP:       prdata = {12'd0, cfg_reg.cap_mw};
            REG_TEMP_MAX:  prdata = {24'd0, cfg_reg.temp_max_c};
            REG_MARGIN:    prdata = {12'd0, cfg_reg.margin_mw};
            REG_RATIO_MAX: prdata = {8'd0, cfg_reg.rest_max_ratio};
            REG_WINDOW:    prdata = {12'd0, cfg_reg.window_ms};
            REG_STEP_UP:   prdata = {8'd0, cfg_reg.step_up};
            REG_STEP_DOWN: prdata = {8'd0, cfg_reg.step_down};
            REG_PAUSE_MAX: prdata = {16'd0, cfg_reg.pause_ceil_ms};
            default:       prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/pcrr_div.sv */
`default_nettype none
module pcrr_div
    import pcrr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              go,
    input  wire logic [DIV_NW-1:0] dividend,
    input  wire logic [DIV_DW-1:0] divisor,
    output logic                   done,
    output logic [DIV_NW-1:0]      quotient
);

    // Restoring division, one quotient bit per cycle. The quotient shifts
    // into the dividend register as the dividend bits shift out.
    logic [DIV_NW-1:0] dvd_reg;
    logic [DIV_DW-1:0] dsr_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [5:0]        cnt_reg;
    logic              done_reg;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    assign rem_sh   = {rem_reg, dvd_reg[DIV_NW-1]};
    assign fits     = rem_sh >= {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                cnt_reg <= 6'(DIV_NW);
            end else if (cnt_reg != 6'd0) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (cnt_reg != 6'd0) begin
            rem_reg <= fits ? DIV_DW'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DIV_DW-1:0];
            dvd_reg <= {dvd_reg[DIV_NW-2:0], fits};
        end
    end

endmodule
`default_nettype wire

/* rtl/pcrr_mul.sv */
`default_nettype none
module pcrr_mul
    import pcrr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             go,
    input  wire logic [MUL_W-1:0] a,
    input  wire logic [MUL_W-1:0] b,
    output logic                  done,
    output logic [2*MUL_W-1:0]    product
);

    // A 32 x 16 multiplier used twice; the partial product is registered
    // before it is added into the accumulator.
    localparam int HW = MUL_W / 2;

    logic [MUL_W-1:0]    a_reg;
    logic [MUL_W-1:0]    b_reg;
    logic [MUL_W+HW-1:0] pp_reg;
    logic [2*MUL_W-1:0]  acc_reg;
    logic [1:0]          ph_reg;
    logic                done_reg;

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= 2'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (ph_reg)
                2'd0: if (go) ph_reg <= 2'd1;
                2'd1: ph_reg <= 2'd2;
                2'd2: ph_reg <= 2'd3;
                2'd3: begin
                    ph_reg   <= 2'd0;
                    done_reg <= 1'b1;
                end
                default: ph_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ph_reg)
            2'd0: begin
                if (go) begin
                    a_reg <= a;
                    b_reg <= b;
                end
            end
            2'd1: pp_reg <= a_reg * b_reg[HW-1:0];
            2'd2: begin
                acc_reg <= {{(MUL_W-HW){1'b0}}, pp_reg};
                pp_reg  <= a_reg * b_reg[MUL_W-1:HW];
            end
            2'd3: acc_reg <= acc_reg + {pp_reg, {HW{1'b0}}};
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

// Bookkeeping for the regulator: a bit-exact predictor of the sample
// pipeline plus a queue of expected results, checked in order.
class rest_regulator_board;
    logic [19:0] cap_mw;
    logic [7:0]  temp_max_c;
    logic [19:0] margin_mw;
    logic [23:0] ratio_max;
    logic [19:0] window_ms;
    logic [23:0] step_up;
    logic [23:0] step_down;
    logic [15:0] pause_ceil_ms;
    logic [31:0] average_q;
    logic [20:0] seen_ms;
    logic [23:0] rest_ratio;
    bit          first_pending;
    logic [60:0] pending_results[$];
    int          error_count;

    function new();
        cap_mw        = pcrr_pkg::CAP_RST;
        temp_max_c    = pcrr_pkg::TEMP_MAX_RST;
        margin_mw     = pcrr_pkg::MARGIN_RST;
        ratio_max     = pcrr_pkg::RATIO_MAX_RST;
        window_ms     = pcrr_pkg::WINDOW_RST;
        step_up       = pcrr_pkg::STEP_UP_RST;
        step_down     = pcrr_pkg::STEP_DOWN_RST;
        pause_ceil_ms = pcrr_pkg::PAUSE_MAX_RST;
        average_q     = '0;
        seen_ms       = '0;
        rest_ratio    = '0;
        first_pending = 1'b1;
        error_count   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            pcrr_pkg::REG_CAP:       cap_mw        = val[19:0];
            pcrr_pkg::REG_TEMP_MAX:  temp_max_c    = val[7:0];
            pcrr_pkg::REG_MARGIN:    margin_mw     = val[19:0];
            pcrr_pkg::REG_RATIO_MAX: ratio_max     = val[23:0];
            pcrr_pkg::REG_WINDOW:    window_ms     = val[19:0];
            pcrr_pkg::REG_STEP_UP:   step_up       = val[23:0];
            pcrr_pkg::REG_STEP_DOWN: step_down     = val[23:0];
            default:                 pause_ceil_ms = val[15:0];
        endcase
    endfunction

    function logic [19:0] eff_window();
        return (window_ms < 20'd500) ? 20'd500 : window_ms;
    endfunction

    // alpha = 1 - exp(-interval/window) in Q30, Taylor sum then five squarings.
    function logic [63:0] alpha_q30(logic [19:0] interval);
        logic [63:0] x16, y, term, r;
        longint      sum;
        x16 = ({44'd0, interval} << 16) / eff_window();
        if (x16 >= (64'd16 << 16)) return 64'd1 << 30;
        y    = x16 << 9;
        sum  = longint'(64'd1 << 30);
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * y) >> 30) / k;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        r = sum;
        if (r > (64'd1 << 30)) r = 64'd1 << 30;
        for (int k = 0; k < 5; k++) r = (r * r) >> 30;
        return (64'd1 << 30) - r;
    endfunction

    function void move_average(logic [19:0] interval, logic [19:0] power);
        logic [63:0] a, target, avg;
        a      = alpha_q30(interval);
        target = {44'd0, power} << 12;
        avg    = {32'd0, average_q};
        if (target >= avg) avg += ((target - avg) * a) >> 30;
        else avg -= ((avg - target) * a) >> 30;
        average_q = avg[31:0];
    endfunction

    function void note_request(bit mode, logic [19:0] interval, logic [19:0] power,
                               logic [7:0] temp, bit valid);
        logic [15:0] pause;
        logic [19:0] dur;
        logic [21:0] seen_sum;
        logic [24:0] raised;
        logic [19:0] cap;
        logic [63:0] p;
        longint      low;
        bit          hot;
        pause = '0;
        if (mode) begin
            if (valid && interval != 0) move_average(interval, power);
        end else if (first_pending) begin
            first_pending = 1'b0;
            if (valid) average_q = {power, 12'd0};
        end else if (valid) begin
            dur = (interval < 20'(pcrr_pkg::MAX_INTERVAL_MS_DEF)) ? interval : 20'd0;
            if (dur != 0) begin
                move_average(dur, power);
                seen_sum = seen_ms + dur;
                seen_ms  = (seen_sum > 22'h1FFFFF) ? 21'h1FFFFF : seen_sum[20:0];
            end
            if (seen_ms >= eff_window()) begin
                cap = (cap_mw < 20'd15000) ? 20'd15000 : cap_mw;
                hot = temp != 0 && temp > temp_max_c;
                low = (longint'(cap) - longint'(margin_mw)) * 4096;
                if (longint'(average_q) > longint'(cap) * 4096 || hot) begin
                    raised     = rest_ratio + step_up;
                    rest_ratio = (raised > ratio_max) ? ratio_max : raised[23:0];
                end else if (longint'(average_q) < low) begin
                    rest_ratio = (rest_ratio > step_down) ? rest_ratio - step_down : '0;
                end
                if (rest_ratio != 0) begin
                    p = dur * rest_ratio;
                    if (p > ({48'd0, pause_ceil_ms} << 16)) pause = pause_ceil_ms;
                    else pause = p[31:16];
                end
            end
        end
        pending_results.push_back({seen_ms >= eff_window(), average_q[31:12],
                                   rest_ratio, pause});
    endfunction

    function void check_result(logic [63:0] data, logic armed);
        logic [60:0] want;
        if (pending_results.size() == 0) begin
            $error("result with no request outstanding");
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (data[15:0] !== want[15:0]) begin
            $error("pause_ms exp %0d got %0d", want[15:0], data[15:0]);
            error_count++;
        end
        if (data[39:16] !== want[39:16]) begin
            $error("rest_ratio_out exp %0d got %0d", want[39:16], data[39:16]);
            error_count++;
        end
        if (data[59:40] !== want[59:40]) begin
            $error("average_mw exp %0d got %0d", want[59:40], data[59:40]);
            error_count++;
        end
        if (data[63:60] !== 4'd0) begin
            $error("pad exp 0 got %0d", data[63:60]);
            error_count++;
        end
        if (armed !== want[60]) begin
            $error("armed exp %0d got %0d", want[60], armed);
            error_count++;
        end
    endfunction
endclass

module tb;
    import pcrr_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // interval_ms [19:0], power_mw [39:20], temp_c [47:40]
    logic [47:0] s_tdata = '0;
    // mode [0], sample_valid [1]
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // pause_ms [15:0], rest_ratio_out [39:16], average_mw [59:40], zero [63:60]
    logic [63:0] m_tdata;
    // armed [0]
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rest_regulator_board board = new();

    // Control of the receiving side: random stalls, a long hold-off on demand,
    // and a calm stretch at the end with no stalls at all.
    bit quiet_tail = 1'b0;
    bit hold_off = 1'b0;
    int requests_sent = 0;

    power_cap_rest_regulator u_dut (.*);

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Results are checked at the rising edge where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
    end

    // Receiver: ready toggles in random bursts, changed on the falling edge.
    initial begin
        int burst;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                burst = $urandom_range(1, 16);
                repeat (burst - 1) begin
                    if (hold_off) break;
                    @(negedge aclk);
                end
            end else begin
                m_tready <= 1'b0;
                burst = $urandom_range(1, 16);
                repeat (burst - 1) @(negedge aclk);
            end
        end
    end

    // One APB write: setup cycle then access cycle, pready is always high.
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // Send one sample request and wait for its acceptance, then record it.
    task automatic send_sample(bit mode, logic [19:0] interval, logic [19:0] power,
                               logic [7:0] temp, bit valid, bit gaps);
        int gap;
        if (gaps && !quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {temp, power, interval};
        s_tuser  <= {valid, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(mode, interval, power, temp, valid);
        requests_sent++;
        @(negedge aclk);
    endtask

    // Wait for every expected result, then let the sequencer drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge aclk);
        repeat (700) @(negedge aclk);
    endtask

    // Random sample: mostly valid boundary steps with plausible intervals
    // so the regulator arms and regulates; some slices, outliers and noise.
    task automatic random_sample(bit gaps);
        bit          mode, valid;
        logic [19:0] interval, power;
        logic [7:0]  temp;
        int          pick;
        mode  = ($urandom_range(0, 4) == 0);
        valid = ($urandom_range(0, 15) != 0);
        pick  = $urandom_range(0, 19);
        if (pick == 0) interval = 20'($urandom);
        else if (pick == 1) interval = 20'($urandom_range(299990, 300010));
        else if (pick == 2) interval = 20'd0;
        else if (pick < 6) interval = 20'($urandom_range(1, 60000));
        else interval = 20'($urandom_range(1, 3000));
        pick = $urandom_range(0, 9);
        if (pick == 0) power = 20'($urandom);
        else power = 20'(board.cap_mw + $urandom_range(0, 80000) - 40000);
        pick = $urandom_range(0, 9);
        if (pick == 0) temp = 8'd0;
        else if (pick < 3) temp = 8'($urandom);
        else temp = 8'(board.temp_max_c + $urandom_range(0, 10) - 5);
        send_sample(mode, interval, power, temp, valid, gaps);
    endtask

    initial begin
        logic [31:0] values[8];
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: seeding, invalid and slice items, interval extremes, arming.
        send_sample(1'b1, 20'hFFFFF, 20'hFFFFF, 8'hFF, 1'b1, 1'b0);
        send_sample(1'b0, 20'd0, 20'd260000, 8'd0, 1'b1, 1'b0);
        send_sample(1'b0, 20'd5000, 20'hFFFFF, 8'hFF, 1'b0, 1'b0);
        send_sample(1'b0, 20'd299999, 20'd300000, 8'd90, 1'b1, 1'b0);
        send_sample(1'b0, 20'd300000, 20'd0, 8'd50, 1'b1, 1'b0);
        send_sample(1'b0, 20'hFFFFF, 20'd0, 8'd0, 1'b1, 1'b0);
        send_sample(1'b0, 20'd1, 20'd0, 8'd0, 1'b1, 1'b0);
        send_sample(1'b1, 20'd0, 20'hFFFFF, 8'd0, 1'b1, 1'b0);
        send_sample(1'b1, 20'd1, 20'hFFFFF, 8'd0, 1'b1, 1'b0);
        send_sample(1'b1, 20'd4000, 20'd0, 8'd0, 1'b0, 1'b0);
        send_sample(1'b0, 20'd2000, 20'd500000, 8'd84, 1'b1, 1'b0);
        send_sample(1'b0, 20'd2000, 20'd1000, 8'd83, 1'b1, 1'b0);
        send_sample(1'b0, 20'd60000, 20'd1000, 8'd20, 1'b1, 1'b0);
        drain();

        // Phases through several register settings, extremes among them.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: values = '{0, 0, 20'hFFFFF, 24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF};
                1: values = '{20'hFFFFF, 8'hFF, 0, 0, 20'hFFFFF, 0, 0, 0};
                2: values = '{15000, 60, 2000, 24'h20000, 500, 5000, 3000, 3000};
                3: values = '{120000, 83, 20000, 24'h10000, 2000, 24'h8000, 24'h4000, 1000};
                4: values = '{14999, 100, 14999, 24'h40000, 499, 24'h1000, 24'h800, 65535};
                default: values = '{250000, 83, 10000, 65536, 10000, 3277, 1638, 2000};
            endcase
            for (int r = 0; r < 8; r++) apb_write(3'(r), values[r]);
            for (int n = 0; n < 320; n++) begin
                if (phase == 5 && n == 200) quiet_tail = 1'b1;
                if (phase == 2 && n == 100) begin
                    // Sender pauses until everything outstanding has come back.
                    s_tvalid <= 1'b0;
                    while (board.pending_results.size() != 0) @(negedge aclk);
                end
                random_sample(1'b1);
            end
            drain();
        end

        // Long receiver hold-off while samples keep coming: the input stalls.
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 6; n++) random_sample(1'b0);
        join
        drain();

        if (board.error_count == 0 && board.pending_results.size() == 0) begin
            $display("power_cap_rest_regulator verification clean");
        end else begin
            $display("power_cap_rest_regulator verification failed");
        end
        $finish;
    end

    // Watchdog: a run that hangs is ended as failed.
    initial begin
        #40ms;
        $display("power_cap_rest_regulator verification failed");
        $finish;
    end
endmodule

/* filelist.f */
rtl/pcrr_pkg.sv
rtl/pcrr_cfg.sv
rtl/pcrr_div.sv
rtl/pcrr_mul.sv
rtl/power_cap_rest_regulator.sv
bench/tb.sv
